/* src/depth_decimate_convert_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the depth decimate/convert block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEPTH_DECIMATE_CONVERT_TOP_MACROS_SVH
`define DEPTH_DECIMATE_CONVERT_TOP_MACROS_SVH

// Same-cycle implication
`define DDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ddc_pkg.sv */
// ----------------------------------------------------------------------------
// ddc_pkg
// Types, register indexes and constants shared by the depth convert block.
// ----------------------------------------------------------------------------
package ddc_pkg;

  // Default sizing
  localparam int MAX_LINE_WIDTH_DEF = 4096;
  localparam int MAX_STEP_DEF       = 16;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // Field widths
  localparam int DEPTH_W = 16;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 3;

  // Meters: floor(d * 65536 / 1000)
  localparam logic [DEPTH_W-1:0] METER_DIVISOR = 16'd1000;

  // 65536 / 1000 = 65 + 67/125, so meters = 65*d + floor(67*d / 125).
  // floor(z / 125) for z < 2^23 is (z * ceil(2^30 / 125)) >> 30, exact.
  localparam logic [7:0]  METER_WHOLE = 8'd65;
  localparam logic [6:0]  METER_PART  = 7'd67;
  localparam logic [23:0] METER_RECIP = 24'd8589935;
  localparam int          METER_SHIFT = 30;

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_OUTPUT_MODE        = 3'd0;
  localparam logic [INDEX_W-1:0] REG_LINE_WIDTH         = 3'd1;
  localparam logic [INDEX_W-1:0] REG_COLUMN_STEP        = 3'd2;
  localparam logic [INDEX_W-1:0] REG_ROW_STEP           = 3'd3;
  localparam logic [INDEX_W-1:0] REG_NO_SAMPLE_CODE     = 3'd4;
  localparam logic [INDEX_W-1:0] REG_SHADOW_CODE        = 3'd5;
  localparam logic [INDEX_W-1:0] REG_DISPARITY_CONSTANT = 3'd6;

  // Output modes
  localparam logic [1:0] MODE_METERS    = 2'd1;
  localparam logic [1:0] MODE_DISPARITY = 2'd2;

  // Register reset values
  localparam logic [11:0] LINE_WIDTH_RST = 12'd640;
  localparam logic [4:0]  STEP_RST       = 5'd1;

  // Work kind of a kept pixel
  typedef enum logic [1:0] {
    OP_RAW   = 2'd0,
    OP_ZERO  = 2'd1,
    OP_METER = 2'd2,
    OP_DISP  = 2'd3
  } op_t;

  // Configuration registers
  typedef struct packed {
    logic [1:0]         output_mode;
    logic [11:0]        line_width;
    logic [4:0]         column_step;
    logic [4:0]         row_step;
    logic [DEPTH_W-1:0] no_sample_code;
    logic [DEPTH_W-1:0] shadow_code;
    logic [VALUE_W-1:0] disparity_constant;
  } cfg_t;

  // One queued kept pixel
  typedef struct packed {
    op_t                op;
    logic [DEPTH_W-1:0] depth;
    logic               invalid;
    logic               line_end;
  } entry_t;

endpackage

/* src/ddc_front.sv */
// ----------------------------------------------------------------------------
// ddc_front
// Tracks raster position, decides which pixels are kept and classifies them.
// ----------------------------------------------------------------------------
module ddc_front #(
  parameter int MAX_LINE_WIDTH = ddc_pkg::MAX_LINE_WIDTH_DEF,
  parameter int MAX_STEP       = ddc_pkg::MAX_STEP_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ddc_pkg::cfg_t                cfg,
  input  logic                         push,
  input  logic [ddc_pkg::DEPTH_W-1:0]  depth_sample,
  input  logic                         frame_start,
  input  logic                         q_full,
  output logic                         q_push,
  output ddc_pkg::entry_t              q_entry
);

  localparam int CW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int SW = $clog2(MAX_STEP + 1);
  localparam int PW = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;

  logic [CW-1:0] column_count;
  logic [PW-1:0] row_phase;
  // col_phase[k] holds the column index modulo k+1
  logic [PW-1:0] col_phase [MAX_STEP];

  logic          accept;
  logic [WW-1:0] w;
  logic [SW-1:0] cs;
  logic [SW-1:0] rs;
  logic [PW-1:0] cs_idx;
  logic [CW-1:0] cur_col;
  logic [PW-1:0] cur_row_raw;
  logic [PW-1:0] cur_row;
  logic [PW-1:0] cur_phase;
  logic          last_in_row;
  logic          kept;
  logic          bad;
  logic          line_end;

  assign accept = push & ~q_full;

  // Effective width and clamped steps
  always_comb begin
    if (cfg.line_width == '0 || 32'(cfg.line_width) > 32'(MAX_LINE_WIDTH)) begin
      w = WW'(MAX_LINE_WIDTH);
    end else begin
      w = WW'(cfg.line_width);
    end
    if (cfg.column_step == '0) begin
      cs = SW'(1);
    end else if (32'(cfg.column_step) > 32'(MAX_STEP)) begin
      cs = SW'(MAX_STEP);
    end else begin
      cs = SW'(cfg.column_step);
    end
    if (cfg.row_step == '0) begin
      rs = SW'(1);
    end else if (32'(cfg.row_step) > 32'(MAX_STEP)) begin
      rs = SW'(MAX_STEP);
    end else begin
      rs = SW'(cfg.row_step);
    end
  end

  assign cs_idx = PW'(cs - SW'(1));

  // Position of this pixel, frame start restarts at the origin
  assign cur_col     = frame_start ? '0 : column_count;
  assign cur_row_raw = frame_start ? '0 : row_phase;
  assign cur_row     = (32'(cur_row_raw) >= 32'(rs)) ? '0 : cur_row_raw;
  assign cur_phase   = frame_start ? '0 : col_phase[cs_idx];

  assign last_in_row = (32'(cur_col) + 32'd1) >= 32'(w);
  assign line_end    = (32'(cur_col) + 32'(cs)) >= 32'(w);
  assign kept        = (cur_row == '0) && (cur_phase == '0);

  // Classification
  assign bad = (depth_sample == '0) || (depth_sample == cfg.no_sample_code) ||
               (depth_sample == cfg.shadow_code);

  always_comb begin
    q_entry.depth    = depth_sample;
    q_entry.invalid  = bad;
    q_entry.line_end = line_end;
    if (bad) begin
      q_entry.op = ddc_pkg::OP_ZERO;
    end else if (cfg.output_mode == ddc_pkg::MODE_METERS) begin
      q_entry.op = ddc_pkg::OP_METER;
    end else if (cfg.output_mode == ddc_pkg::MODE_DISPARITY) begin
      q_entry.op = ddc_pkg::OP_DISP;
    end else begin
      q_entry.op = ddc_pkg::OP_RAW;
    end
  end

  assign q_push = accept & kept;

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_phase    <= '0;
      for (int k = 0; k < MAX_STEP; k++) begin
        col_phase[k] <= '0;
      end
    end else if (accept) begin
      if (last_in_row) begin
        column_count <= '0;
        row_phase    <= ((32'(cur_row) + 32'd1) >= 32'(rs)) ? '0 : cur_row + PW'(1);
      end else begin
        column_count <= cur_col + CW'(1);
        row_phase    <= cur_row;
      end
      for (int k = 0; k < MAX_STEP; k++) begin
        if (last_in_row || frame_start) begin
          col_phase[k] <= (last_in_row || k == 0) ? '0 : PW'(1);
        end else if (32'(col_phase[k]) == k) begin
          col_phase[k] <= '0;
        end else begin
          col_phase[k] <= col_phase[k] + PW'(1);
        end
      end
    end
  end

endmodule

/* src/ddc_queue.sv */
// ----------------------------------------------------------------------------
// ddc_queue
// Short first-in first-out queue of kept pixels between front and back.
// ----------------------------------------------------------------------------
module ddc_queue #(
  parameter int DEPTH = ddc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ddc_pkg::entry_t wr_data,
  input  logic            rd_en,
  output ddc_pkg::entry_t rd_data,
  output logic            q_empty,
  output logic            q_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  ddc_pkg::entry_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [NW-1:0]   fill;

  assign q_empty = (fill == '0);
  assign q_full  = (32'(fill) == DEPTH);
  assign rd_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + NW'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

/* src/ddc_back.sv */
// ----------------------------------------------------------------------------
// ddc_back
// Converts queued pixels (reciprocal multiply for meters, bit-serial divider
// for disparity) and holds the result.
// ----------------------------------------------------------------------------
`include "depth_decimate_convert_top_macros.svh"

module ddc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ddc_pkg::VALUE_W-1:0]  disparity_constant,
  input  logic                         q_empty,
  input  ddc_pkg::entry_t              q_entry,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic [ddc_pkg::VALUE_W-1:0]  out_value,
  output logic                         invalid,
  output logic                         line_end
);

  localparam int DW  = ddc_pkg::DEPTH_W;
  localparam int VW  = ddc_pkg::VALUE_W;
  localparam int KW  = $clog2(VW);
  localparam int MW  = 23;
  localparam int MPW = MW + $bits(ddc_pkg::METER_RECIP);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t         state;
  state_t         state_next;
  logic [KW-1:0]  div_cnt;
  logic [VW-1:0]  quo;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  divisor;
  logic           div_line_end;
  logic           out_valid;
  logic [MW-1:0]  mtr_base;
  logic [MW-1:0]  mtr_part;

  logic           out_free;
  logic           direct;
  logic           load_direct;
  logic           load_mul;
  logic           load_div;
  logic           load_done;
  logic [DW:0]    trial;
  logic           trial_ge;
  logic [MPW-1:0] mtr_prod;
  logic [VW-1:0]  mtr_value;

  assign out_free = ~out_valid | pop;
  assign empty    = ~out_valid;

  // Raw and invalid pixels skip the arithmetic
  assign direct      = (q_entry.op == ddc_pkg::OP_RAW) || (q_entry.op == ddc_pkg::OP_ZERO);
  assign load_direct = (state == ST_IDLE) && !q_empty && direct && out_free;
  assign load_mul    = (state == ST_IDLE) && !q_empty && (q_entry.op == ddc_pkg::OP_METER);
  assign load_div    = (state == ST_IDLE) && !q_empty && (q_entry.op == ddc_pkg::OP_DISP);
  assign load_done   = (state == ST_DONE) && out_free;
  assign q_pop       = load_direct | load_mul | load_div;

  // One restoring divide step
  assign trial    = {rem, quo[VW-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  // Meters: 65*d plus 67*d/125 by reciprocal multiply
  assign mtr_prod  = MPW'(mtr_part) * MPW'(ddc_pkg::METER_RECIP);
  assign mtr_value = VW'(mtr_base) + VW'(mtr_prod[MPW-1:ddc_pkg::METER_SHIFT]);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (load_div) begin
          state_next = ST_DIV;
        end else if (load_mul) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_DONE;
      ST_DIV:  if (div_cnt == '0) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_direct || load_done) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Multiply and divider datapath
  always_ff @(posedge clk) begin
    if (load_div || load_mul) begin
      div_line_end <= q_entry.line_end;
    end
    if (load_mul) begin
      mtr_base <= MW'(q_entry.depth) * MW'(ddc_pkg::METER_WHOLE);
      mtr_part <= MW'(q_entry.depth) * MW'(ddc_pkg::METER_PART);
    end
    if (load_div) begin
      div_cnt <= KW'(VW - 1);
      rem     <= '0;
      quo     <= disparity_constant;
      divisor <= q_entry.depth;
    end else if (state == ST_DIV) begin
      div_cnt <= div_cnt - KW'(1);
      rem     <= trial_ge ? DW'(trial - {1'b0, divisor}) : DW'(trial);
      quo     <= {quo[VW-2:0], trial_ge};
    end else if (state == ST_MUL) begin
      quo <= mtr_value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_direct) begin
      out_value <= (q_entry.op == ddc_pkg::OP_ZERO) ? '0 : VW'(q_entry.depth);
      invalid   <= q_entry.invalid;
      line_end  <= q_entry.line_end;
    end else if (load_done) begin
      out_value <= quo;
      invalid   <= 1'b0;
      line_end  <= div_line_end;
    end
  end

  `DDC_ASSERT_NOW(a_pop_has_entry, q_pop, !q_empty, "queue pop while queue is empty")
  `DDC_ASSERT_NOW(a_div_nonzero, state == ST_DIV, divisor != '0, "divider runs on zero divisor")
  `DDC_ASSERT_NEXT(a_div_finishes, (state == ST_DIV) && (div_cnt == '0), state == ST_DONE,
    "divider did not finish after last step")
  `DDC_ASSERT_NEXT(a_done_loads, load_done, out_valid && (state == ST_IDLE),
    "quotient not placed in result register")

endmodule

/* src/depth_decimate_convert_top.sv */
// ----------------------------------------------------------------------------
// depth_decimate_convert_top
// Decimating depth pixel converter: raw millimeters, meters or disparity.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock whenever the kept-pixel queue has room.
// Skipped pixels, and kept pixels in raw mode or marked invalid, pass at one
// per clock while results are popped. A kept valid pixel in meters mode goes
// through queue pop, reciprocal multiply and result load in the back end; in
// disparity mode it goes through a one-bit-per-cycle divider (queue pop, 32
// divide steps, result load). The front keeps accepting pixels until
// QUEUE_DEPTH kept pixels wait; a full queue stalls every pixel, skipped ones
// too. A result not yet popped holds the back end.
module depth_decimate_convert_top #(
  parameter int MAX_LINE_WIDTH = ddc_pkg::MAX_LINE_WIDTH_DEF,
  parameter int MAX_STEP       = ddc_pkg::MAX_STEP_DEF,
  parameter int QUEUE_DEPTH    = ddc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // pixel input
  input  logic                         push,
  output logic                         full,
  input  logic [ddc_pkg::DEPTH_W-1:0]  depth_sample,
  input  logic                         frame_start,
  // results
  output logic                         empty,
  input  logic                         pop,
  output logic [ddc_pkg::VALUE_W-1:0]  out_value,
  output logic                         invalid,
  output logic                         line_end,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ddc_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [ddc_pkg::VALUE_W-1:0]  cfg_data
);

  ddc_pkg::cfg_t   cfg;
  ddc_pkg::entry_t push_entry;
  ddc_pkg::entry_t head_entry;
  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  logic            q_full;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_mode        <= '0;
      cfg.line_width         <= ddc_pkg::LINE_WIDTH_RST;
      cfg.column_step        <= ddc_pkg::STEP_RST;
      cfg.row_step           <= ddc_pkg::STEP_RST;
      cfg.no_sample_code     <= '0;
      cfg.shadow_code        <= '0;
      cfg.disparity_constant <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ddc_pkg::REG_OUTPUT_MODE:        cfg.output_mode        <= cfg_data[1:0];
        ddc_pkg::REG_LINE_WIDTH:         cfg.line_width         <= cfg_data[11:0];
        ddc_pkg::REG_COLUMN_STEP:        cfg.column_step        <= cfg_data[4:0];
        ddc_pkg::REG_ROW_STEP:           cfg.row_step           <= cfg_data[4:0];
        ddc_pkg::REG_NO_SAMPLE_CODE:     cfg.no_sample_code     <= cfg_data[15:0];
        ddc_pkg::REG_SHADOW_CODE:        cfg.shadow_code        <= cfg_data[15:0];
        ddc_pkg::REG_DISPARITY_CONSTANT: cfg.disparity_constant <= cfg_data;
        default: ;
      endcase
    end
  end

  ddc_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .MAX_STEP       (MAX_STEP)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .depth_sample (depth_sample),
    .frame_start  (frame_start),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  ddc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (push_entry),
    .rd_en   (q_pop),
    .rd_data (head_entry),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  ddc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .disparity_constant (cfg.disparity_constant),
    .q_empty            (q_empty),
    .q_entry            (head_entry),
    .q_pop              (q_pop),
    .pop                (pop),
    .empty              (empty),
    .out_value          (out_value),
    .invalid            (invalid),
    .line_end           (line_end)
  );

endmodule
